@@ rtl/sorted_wakeup_timer_queue_macros.svh @@
// Assertion macros for the sorted wake-up timer queue.
// No dependencies; included by the files that carry assertions.
`ifndef SORTED_WAKEUP_TIMER_QUEUE_MACROS_SVH
`define SORTED_WAKEUP_TIMER_QUEUE_MACROS_SVH
`ifndef SYNTH
`define SWTQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swtq assertion failed");
`define SWTQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swtq assertion failed");
`else
`define SWTQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SWTQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/swtq_pkg.sv @@
// Types, constants and helpers for the sorted wake-up timer queue.
// No dependencies.
package swtq_pkg;

  localparam int QUEUE_SLOTS = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TIME_W      = 63;
  localparam int ID_W        = 8;
  localparam int TICKS_W     = 32;
  localparam int IDX_W       = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(QUEUE_SLOTS + 1);

  typedef enum logic {
    KIND_SLEEP = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_WOKEN   = 2'd0,
    ST_QUEUED  = 2'd1,
    ST_IGNORED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_HEAD,
    S_REPLY,
    S_TK_RD,
    S_TK_CMP,
    S_TK_FIN
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] wake;
    logic [ID_W-1:0]   sleeper;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Logical queue position to physical slot of the ring.
  function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
    if (sum >= (CNT_W+1)'(QUEUE_SLOTS)) begin
      sum = sum - (CNT_W+1)'(QUEUE_SLOTS);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/swtq_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module swtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/sorted_wakeup_timer_queue.sv @@
// Sorted wake-up timer queue: top level with control FSM and queue ring.
// Depends on swtq_pkg, swtq_ram and sorted_wakeup_timer_queue_macros.svh.
//
// Usage: the input channel (in_valid / in_stall) takes one beat per item:
// kind = tick or sleep request, with sleeper_id and sleep_ticks. The output
// channel (out_valid / out_stall) returns result beats: status, woken_id and
// last, which marks the final beat of an item. A sleep request always gives
// one beat; a tick gives zero or more woken beats, earliest wake time first.
// Entries sit in a ring in one RAM (registered read) ordered by wake time.
// One item at a time. A queued sleep request walks the ring back from the
// tail one slot per cycle (read one slot, write the next) past the queued
// entries with a later wake time; an ignored or full request goes straight
// to its reply. A tick reads and checks the entries from the head in order,
// one RAM read per due check, until one is not yet due, none is left or
// MAX_RESULTS are woken. in_stall is high whenever an item is being worked on.
// When out_stall holds a result, the walk pauses at that point and resumes
// once the output register frees up; nothing is dropped.
// Reset clears the tick counter and empties the queue; RAM contents stay
// undefined and are only read below the fill count.
module sorted_wakeup_timer_queue
  import swtq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [ID_W-1:0]    sleeper_id,
  input  logic [TICKS_W-1:0] sleep_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [ID_W-1:0]    woken_id,
  output logic               last
);

  `include "sorted_wakeup_timer_queue_macros.svh"

  state_t             state, state_next;
  logic [TIME_W-1:0]  tick_count;
  logic [IDX_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   ins_pos;
  logic [CNT_W-1:0]   n;
  logic [TIME_W-1:0]  wake;
  logic [ID_W-1:0]    new_id;
  status_t            reply_status;
  logic               pend_valid;
  logic [ID_W-1:0]    pend_id;
  status_t            out_status;

  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  entry_t             wr_data, rd_data;

  logic               emit;
  status_t            emit_status;
  logic [ID_W-1:0]    emit_id;
  logic               emit_last;

  logic               out_free;
  logic               req_ignored;
  logic               req_full;
  logic               ins_le;
  logic               tk_due;
  logic               tk_more;
  logic [TIME_W-1:0]  wake_calc;
  entry_t             new_entry;

  swtq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != S_IDLE);
  assign req_ignored = (sleep_ticks == '0) || sleep_ticks[TICKS_W-1];
  assign req_full    = (int'(count) >= QUEUE_SLOTS);
  assign wake_calc   = tick_count + TIME_W'(sleep_ticks[TICKS_W-2:0]);
  assign ins_le      = (rd_data.wake <= wake);
  assign tk_due      = (rd_data.wake <= tick_count);
  assign tk_more     = (n < count) && (int'(n) < MAX_RESULTS);
  assign new_entry   = '{wake: wake, sleeper: new_id};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_TICK) begin
            state_next = S_TK_RD;
          end else if (req_ignored || req_full) begin
            state_next = S_REPLY;
          end else if (count == '0) begin
            state_next = S_INS_HEAD;
          end else begin
            state_next = S_INS_CMP;
          end
        end
      end
      S_INS_CMP: begin
        if (ins_le) begin
          state_next = S_REPLY;
        end else if (ins_pos == CNT_W'(1)) begin
          state_next = S_INS_HEAD;
        end
      end
      S_INS_HEAD: state_next = S_REPLY;
      S_REPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_TK_RD: state_next = tk_more ? S_TK_CMP : S_TK_FIN;
      S_TK_CMP: begin
        if (!tk_due) begin
          state_next = S_TK_FIN;
        end else if (!pend_valid || out_free) begin
          state_next = S_TK_RD;
        end
      end
      S_TK_FIN: begin
        if (!pend_valid || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = new_entry;
    emit        = 1'b0;
    emit_status = ST_WOKEN;
    emit_id     = pend_id;
    emit_last   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && (kind == KIND_SLEEP) && !req_ignored && !req_full &&
            (count != '0)) begin
          rd_en   = 1'b1;
          rd_addr = slot_addr(head, count - CNT_W'(1));
        end
      end
      S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = slot_addr(head, ins_pos);
        if (!ins_le) begin
          wr_data = rd_data;
          if (ins_pos > CNT_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = slot_addr(head, (ins_pos - CNT_W'(1)) - CNT_W'(1));
          end
        end
      end
      S_INS_HEAD: begin
        wr_en   = 1'b1;
        wr_addr = slot_addr(head, '0);
      end
      S_REPLY: begin
        emit        = out_free;
        emit_status = reply_status;
        emit_id     = new_id;
        emit_last   = 1'b1;
      end
      S_TK_RD: begin
        if (tk_more) begin
          rd_en   = 1'b1;
          rd_addr = slot_addr(head, n);
        end
      end
      S_TK_CMP: begin
        emit = tk_due && pend_valid && out_free;
      end
      S_TK_FIN: begin
        emit      = pend_valid && out_free;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= '0;
      head       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && (kind == KIND_TICK)) begin
            tick_count <= tick_count + TIME_W'(1);
          end
        end
        S_INS_CMP: begin
          if (ins_le) begin
            count <= count + CNT_W'(1);
          end
        end
        S_INS_HEAD: count <= count + CNT_W'(1);
        S_TK_CMP: begin
          if (tk_due && (!pend_valid || out_free)) begin
            pend_valid <= 1'b1;
          end
        end
        S_TK_FIN: begin
          if (!pend_valid || out_free) begin
            head       <= slot_addr(head, n);
            count      <= count - n;
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status <= emit_status;
      woken_id   <= emit_id;
      last       <= emit_last;
    end
    case (state)
      S_IDLE: begin
        new_id  <= sleeper_id;
        wake    <= wake_calc;
        ins_pos <= count;
        n       <= '0;
        if (req_ignored) begin
          reply_status <= ST_IGNORED;
        end else if (req_full) begin
          reply_status <= ST_FULL;
        end else begin
          reply_status <= ST_QUEUED;
        end
      end
      S_INS_CMP: begin
        if (!ins_le) begin
          ins_pos <= ins_pos - CNT_W'(1);
        end
      end
      S_TK_CMP: begin
        if (tk_due && (!pend_valid || out_free)) begin
          pend_id <= rd_data.sleeper;
          n       <= n + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign status = out_status;

  `SWTQ_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, int'(count) <= QUEUE_SLOTS)
  `SWTQ_ASSERT_NEXT(a_tick_adv, clk, rst, in_valid && !in_stall && (kind == KIND_TICK),
                    tick_count == $past(tick_count) + TIME_W'(1))
  `SWTQ_ASSERT_IMPL(a_reply_last, clk, rst, out_valid && (out_status != ST_WOKEN), last)
  `SWTQ_ASSERT_IMPL(a_rw_apart, clk, rst, wr_en && rd_en, wr_addr != rd_addr)

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sorted_wakeup_timer_queue: directed and random
// sleep requests and ticks against an in-bench model of the wake-up queue.
// Depends on swtq_pkg and the sorted_wakeup_timer_queue RTL.
module testbench;
  import swtq_pkg::*;

  localparam int IDLE_PCT       = 22;
  localparam int RANDOM_ITEMS   = 256;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;
  localparam int TAIL_CYCLES    = 50;

  typedef struct {
    kind_t             k;
    logic [ID_W-1:0]   id;
    logic [TICKS_W-1:0] ticks;
  } request_t;

  typedef struct {
    status_t         status;
    logic [ID_W-1:0] id;
    logic            last;
  } wake_result_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [ID_W-1:0] sleeper_id = '0;
  logic [TICKS_W-1:0] sleep_ticks = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [ID_W-1:0] woken_id;
  logic last;

  request_t     request_backlog[$];
  wake_result_t due_results[$];
  entry_t       sleep_queue[$];
  logic [TIME_W-1:0] now_ticks;

  int  accepted_items = 0;
  int  mismatches = 0;
  int  idle_cycles = 0;
  logic quiet;

  sorted_wakeup_timer_queue uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .sleeper_id (sleeper_id),
    .sleep_ticks(sleep_ticks),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .woken_id   (woken_id),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // no random idling on either side over this stretch
  assign quiet = (accepted_items >= 100) && (accepted_items < 170);

  task automatic add_request(kind_t k, logic [ID_W-1:0] id, logic [TICKS_W-1:0] ticks);
    request_t r;
    r.k = k;
    r.id = id;
    r.ticks = ticks;
    request_backlog.push_back(r);
  endtask

  task automatic push_result(status_t st, logic [ID_W-1:0] id, logic lst);
    wake_result_t w;
    w.status = st;
    w.id = id;
    w.last = lst;
    due_results.push_back(w);
  endtask

  // Applies one accepted beat to the queue model and records its results.
  task automatic advance_timer_model(kind_t k, logic [ID_W-1:0] id,
                                     logic [TICKS_W-1:0] ticks);
    entry_t e;
    entry_t woken[$];
    int pos;
    if (k == KIND_SLEEP) begin
      if (ticks == '0 || ticks[TICKS_W-1]) begin
        push_result(ST_IGNORED, id, 1'b1);
      end else if (sleep_queue.size() >= QUEUE_SLOTS) begin
        push_result(ST_FULL, id, 1'b1);
      end else begin
        e.wake = now_ticks + TIME_W'(ticks);
        e.sleeper = id;
        pos = 0;
        while (pos < sleep_queue.size() && sleep_queue[pos].wake <= e.wake) pos++;
        sleep_queue.insert(pos, e);
        push_result(ST_QUEUED, id, 1'b1);
      end
    end else begin
      now_ticks = now_ticks + 1'b1;
      while (sleep_queue.size() != 0 && woken.size() < MAX_RESULTS &&
             sleep_queue[0].wake <= now_ticks) begin
        woken.push_back(sleep_queue.pop_front());
      end
      foreach (woken[i]) push_result(ST_WOKEN, woken[i].sleeper, i == woken.size() - 1);
    end
  endtask

  task automatic report_mismatch(string what);
    if (mismatches < REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    logic send;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_timer_model(kind_t'(kind), sleeper_id, sleep_ticks);
        accepted_items <= accepted_items + 1;
      end
      if (!in_valid || !in_stall) begin
        send = (request_backlog.size() != 0) &&
               (quiet || $urandom_range(0, 99) >= IDLE_PCT);
        if (send) begin
          nxt = request_backlog.pop_front();
          kind <= nxt.k;
          sleeper_id <= nxt.id;
          sleep_ticks <= nxt.ticks;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_results
    wake_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected beat status=%0d id=%0d last=%0b",
                                    status, woken_id, last));
        end else begin
          want = due_results.pop_front();
          if (status !== want.status || woken_id !== want.id || last !== want.last) begin
            report_mismatch($sformatf(
                "expected status=%0d id=%0d last=%0b, got status=%0d id=%0d last=%0b",
                want.status, want.id, want.last, status, woken_id, last));
          end
        end
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run
    int pick;
    now_ticks = '0;

    // ignored durations, an empty tick, a never-due sleeper
    add_request(KIND_SLEEP, 8'h00, 32'h0000_0000);
    add_request(KIND_SLEEP, 8'hFF, 32'hFFFF_FFFF);
    add_request(KIND_SLEEP, 8'h80, 32'h8000_0000);
    add_request(KIND_TICK, 8'h5A, 32'h1234_5678);
    add_request(KIND_SLEEP, 8'hFF, 32'h7FFF_FFFF);
    // fill to capacity with equal wake times, then overflow
    for (int i = 1; i <= 15; i++) begin
      add_request(KIND_SLEEP, ID_W'(i), (i % 4 == 0) ? 32'd1 : 32'd2);
    end
    add_request(KIND_SLEEP, 8'd200, 32'd1);
    // releases three, then twelve in one burst, then nothing
    repeat (3) add_request(KIND_TICK, ID_W'($urandom), $urandom);

    while (request_backlog.size() < 24 + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        repeat ($urandom_range(4, 18)) begin
          add_request(KIND_SLEEP, ID_W'($urandom), $urandom_range(1, 10));
        end
      end else if (pick < 20) begin
        repeat ($urandom_range(3, 12)) add_request(KIND_TICK, ID_W'($urandom), $urandom);
      end else if (pick < 48) begin
        add_request(KIND_SLEEP, ID_W'($urandom), $urandom_range(1, 12));
      end else if (pick < 82) begin
        add_request(KIND_TICK, ID_W'($urandom), $urandom);
      end else if (pick < 91) begin
        add_request(KIND_SLEEP, ID_W'($urandom), {1'b1, 31'($urandom)});
      end else if (pick < 95) begin
        add_request(KIND_SLEEP, ID_W'($urandom), 32'd0);
      end else if (pick < 99) begin
        add_request(KIND_SLEEP, ID_W'($urandom), $urandom_range(20, 80));
      end else begin
        add_request(KIND_SLEEP, ID_W'($urandom), {1'b0, 31'($urandom)});
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0 || in_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
